@@ hw/rtl/ecal_pkg.sv @@
// ----------------------------------------------------------------------------
// ecal_pkg
// Types and constants shared by the epoch-to-calendar pipeline.
// ----------------------------------------------------------------------------
package ecal_pkg;

    // Reciprocal of 15 scaled by 2^35, rounded up; used for x/60 as (x>>2)/15.
    localparam int            DIV15_SHIFT = 35;
    localparam logic [31:0]   DIV15_MUL   = 32'(((64'd1 << DIV15_SHIFT) + 64'd14) / 64'd15);

    // Four-year cycle: 1461 days in hours, and its scaled reciprocal.
    localparam logic [22:0]   CYC_HOURS   = 23'(1461 * 24);
    localparam int            CYC_SHIFT   = 40;
    localparam logic [24:0]   CYC_MUL     = 25'(((64'd1 << CYC_SHIFT) + 64'd35063) / 64'd35064);

    // Hour marks of year starts inside a cycle (cycle starts on a year = 2 mod 4).
    localparam logic [15:0]   YR1_START   = 16'(365 * 24);
    localparam logic [15:0]   YR2_START   = 16'(2 * 365 * 24);
    localparam logic [15:0]   YR3_START   = 16'(3 * 365 * 24 + 24);

    localparam logic [8:0]    YEAR_BASE   = 9'd70;
    localparam logic [8:0]    LEAP_DAY    = 9'd60;
    localparam logic [1:0]    LEAP_SLOT   = 2'd2;
    localparam logic [4:0]    FEB29_MDAY  = 5'd29;
    localparam logic [3:0]    MONTH_FEB   = 4'd1;
    localparam logic [3:0]    MONTH_DEC   = 4'd11;

    typedef struct packed {
        logic [5:0]  sec_field;
        logic [5:0]  min_field;
        logic [6:0]  cycles;
        logic [15:0] cyc_hours;
    } t_split;

    typedef struct packed {
        logic [7:0]  year_offset;
        logic [3:0]  month_index;
        logic [4:0]  day_of_month;
        logic [4:0]  hour_field;
        logic [5:0]  min_field;
        logic [5:0]  sec_field;
    } t_cal;

    // Last day of year of each month, non-leap.
    function automatic logic [8:0] month_end(input logic [3:0] mon);
        logic [8:0] v;
        case (mon)
            4'd0:    v = 9'd31;
            4'd1:    v = 9'd59;
            4'd2:    v = 9'd90;
            4'd3:    v = 9'd120;
            4'd4:    v = 9'd151;
            4'd5:    v = 9'd181;
            4'd6:    v = 9'd212;
            4'd7:    v = 9'd243;
            4'd8:    v = 9'd273;
            4'd9:    v = 9'd304;
            4'd10:   v = 9'd334;
            default: v = 9'd365;
        endcase
        return v;
    endfunction

    // Days before the first of each month, non-leap.
    function automatic logic [8:0] month_start(input logic [3:0] mon);
        logic [8:0] v;
        case (mon)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            default: v = 9'd334;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/ecal_split.sv @@
// ----------------------------------------------------------------------------
// ecal_split
// Splits local seconds into second, minute, four-year cycle and hour in cycle.
// Six stages: reciprocal multiply and remainder fix-up for /60, /60, /35064.
// ----------------------------------------------------------------------------
module ecal_split import ecal_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    output logic        o_rdy,
    input  logic [32:0] i_time,
    output logic        o_vld,
    input  logic        i_rdy,
    output t_split      o_data
);

    logic [5:0]  r_v;
    logic [6:0]  w_rdy;

    // stage 2: estimate t/60
    logic [32:0] r_t2;
    logic [27:0] r_q2;
    // stage 3: fix remainder
    logic [5:0]  r_sec3;
    logic [27:0] r_m3;
    // stage 4: estimate m/60
    logic [5:0]  r_sec4;
    logic [27:0] r_m4;
    logic [21:0] r_q4;
    // stage 5
    logic [5:0]  r_sec5;
    logic [5:0]  r_min5;
    logic [21:0] r_h5;
    // stage 6: estimate h/35064
    logic [5:0]  r_sec6;
    logic [5:0]  r_min6;
    logic [21:0] r_h6;
    logic [6:0]  r_q6;
    // stage 7
    t_split      r_out7;

    logic [62:0] w_prod2;
    logic [33:0] w_p3;
    logic [33:0] w_r3;
    logic [57:0] w_prod4;
    logic [28:0] w_p5;
    logic [28:0] w_r5;
    logic [46:0] w_prod6;
    logic [22:0] w_p7;
    logic [22:0] w_r7;

    always_comb begin
        w_rdy[6] = i_rdy;
        for (int k = 5; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end
    assign o_rdy  = w_rdy[0];
    assign o_vld  = r_v[5];
    assign o_data = r_out7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_vld;
            for (int k = 1; k < 6; k++) begin
                if (w_rdy[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    assign w_prod2 = {32'b0, i_time[32:2]} * {31'b0, DIV15_MUL};
    assign w_p3    = {r_q2, 6'b0} - {4'b0, r_q2, 2'b0};
    assign w_r3    = {1'b0, r_t2} - w_p3;
    assign w_prod4 = {32'b0, r_m3[27:2]} * {26'b0, DIV15_MUL};
    assign w_p5    = {1'b0, r_q4, 6'b0} - {5'b0, r_q4, 2'b0};
    assign w_r5    = {1'b0, r_m4} - w_p5;
    assign w_prod6 = {25'b0, r_h5} * {22'b0, CYC_MUL};
    assign w_p7    = {16'b0, r_q6} * CYC_HOURS;
    assign w_r7    = {1'b0, r_h6} - w_p7;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_vld) begin
            r_t2 <= i_time;
            r_q2 <= w_prod2[62:35];
        end
        if (w_rdy[1] && r_v[0]) begin
            // estimate may be one high; remainder then comes out negative
            if (w_r3[33]) begin
                r_m3   <= r_q2 - 28'd1;
                r_sec3 <= w_r3[5:0] + 6'd60;
            end else begin
                r_m3   <= r_q2;
                r_sec3 <= w_r3[5:0];
            end
        end
        if (w_rdy[2] && r_v[1]) begin
            r_sec4 <= r_sec3;
            r_m4   <= r_m3;
            r_q4   <= w_prod4[56:35];
        end
        if (w_rdy[3] && r_v[2]) begin
            r_sec5 <= r_sec4;
            if (w_r5[28]) begin
                r_h5   <= r_q4 - 22'd1;
                r_min5 <= w_r5[5:0] + 6'd60;
            end else begin
                r_h5   <= r_q4;
                r_min5 <= w_r5[5:0];
            end
        end
        if (w_rdy[4] && r_v[3]) begin
            r_sec6 <= r_sec5;
            r_min6 <= r_min5;
            r_h6   <= r_h5;
            r_q6   <= w_prod6[46:40];
        end
        if (w_rdy[5] && r_v[4]) begin
            r_out7.sec_field <= r_sec6;
            r_out7.min_field <= r_min6;
            if (w_r7[22]) begin
                r_out7.cycles    <= r_q6 - 7'd1;
                r_out7.cyc_hours <= w_r7[15:0] + CYC_HOURS[15:0];
            end else begin
                r_out7.cycles    <= r_q6;
                r_out7.cyc_hours <= w_r7[15:0];
            end
        end
    end

    a_sec_min_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[3] |-> (r_sec5 < 6'd60) && (r_min5 < 6'd60))
        else $error("second or minute out of range after fix-up");

    a_cycle_hours_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[5] |-> ({7'b0, r_out7.cyc_hours} < CYC_HOURS))
        else $error("hour in cycle out of range");

endmodule

@@ hw/rtl/ecal_date.sv @@
// ----------------------------------------------------------------------------
// ecal_date
// Year within the cycle, hour of day, day of year, then month and day.
// Three stages; the last one is the output register.
// ----------------------------------------------------------------------------
module ecal_date import ecal_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_vld,
    output logic   o_rdy,
    input  t_split i_data,
    output logic   o_vld,
    input  logic   i_rdy,
    output t_cal   o_res
);

    logic [2:0]  r_v;
    logic [3:0]  w_rdy;

    logic [5:0]  r_sec8, r_sec9;
    logic [5:0]  r_min8, r_min9;
    logic [8:0]  r_year8, r_year9;
    logic        r_leap8, r_leap9;
    logic [13:0] r_hy8;
    logic [4:0]  r_hour9;
    logic [8:0]  r_day9;
    t_cal        r_res;

    logic [1:0]  w_slot;
    logic [15:0] w_base;
    logic [15:0] w_hy;
    logic [20:0] w_prod9;
    logic [8:0]  w_d0;
    logic [13:0] w_hrem;
    logic [8:0]  w_dd;
    logic        w_feb29;
    logic [3:0]  w_mon;
    logic [8:0]  w_mday;

    always_comb begin
        w_rdy[3] = i_rdy;
        for (int k = 2; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end
    assign o_rdy = w_rdy[0];
    assign o_vld = r_v[2];
    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_vld;
            if (w_rdy[1]) r_v[1] <= r_v[0];
            if (w_rdy[2]) r_v[2] <= r_v[1];
        end
    end

    // cycle years run 365, 365, 366, 365
    always_comb begin
        if (i_data.cyc_hours >= YR3_START) begin
            w_slot = 2'd3;
            w_base = YR3_START;
        end else if (i_data.cyc_hours >= YR2_START) begin
            w_slot = 2'd2;
            w_base = YR2_START;
        end else if (i_data.cyc_hours >= YR1_START) begin
            w_slot = 2'd1;
            w_base = YR1_START;
        end else begin
            w_slot = 2'd0;
            w_base = '0;
        end
        w_hy = i_data.cyc_hours - w_base;
    end

    // hours/24 as ((h>>3) * 683) >> 11, exact for h < 8784
    assign w_prod9 = {10'b0, r_hy8[13:3]} * 21'd683;
    assign w_d0    = w_prod9[19:11];
    assign w_hrem  = r_hy8 - ({5'b0, w_d0} * 14'd24);

    always_comb begin
        w_feb29 = r_leap9 && (r_day9 == LEAP_DAY);
        w_dd    = (r_leap9 && (r_day9 > LEAP_DAY)) ? r_day9 - 9'd1 : r_day9;
        w_mon   = MONTH_DEC;
        for (int k = 10; k >= 0; k--) begin
            if (w_dd <= month_end(4'(k))) w_mon = 4'(k);
        end
        w_mday  = w_dd - month_start(w_mon);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_vld) begin
            r_sec8  <= i_data.sec_field;
            r_min8  <= i_data.min_field;
            r_year8 <= YEAR_BASE + {i_data.cycles, 2'b0} + {7'b0, w_slot};
            r_leap8 <= (w_slot == LEAP_SLOT);
            r_hy8   <= w_hy[13:0];
        end
        if (w_rdy[1] && r_v[0]) begin
            r_sec9  <= r_sec8;
            r_min9  <= r_min8;
            r_year9 <= r_year8;
            r_leap9 <= r_leap8;
            r_hour9 <= w_hrem[4:0];
            r_day9  <= w_d0 + 9'd1;
        end
        if (w_rdy[2] && r_v[1]) begin
            r_res.sec_field   <= r_sec9;
            r_res.min_field   <= r_min9;
            r_res.hour_field  <= r_hour9;
            r_res.year_offset <= r_year9[7:0];
            if (w_feb29) begin
                r_res.day_of_month <= FEB29_MDAY;
                r_res.month_index  <= MONTH_FEB;
            end else begin
                r_res.day_of_month <= w_mday[4:0];
                r_res.month_index  <= w_mon;
            end
        end
    end

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] |-> (r_res.month_index <= MONTH_DEC))
        else $error("month index out of range");

    a_mday_fits_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] |-> (r_res.day_of_month != 5'd0) &&
                   ({4'b0, r_res.day_of_month} <=
                    month_end(r_res.month_index) - month_start(r_res.month_index) ||
                    (r_res.month_index == MONTH_FEB && r_res.day_of_month == FEB29_MDAY)))
        else $error("day of month does not fit month");

    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] |-> (r_res.hour_field < 5'd24))
        else $error("hour out of range");

endmodule

@@ hw/rtl/epoch_seconds_to_calendar_core.sv @@
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core
// Unix epoch seconds to calendar date and time of day.
// ----------------------------------------------------------------------------
// Converts a 32-bit epoch seconds count, minus the programmed zone offset
// (negative results clamp to 1970-01-01 00:00:00), into second, minute, hour,
// day of month, month (0 = January) and year minus 1900. Every year divisible
// by four counts as a leap year. The pipeline takes one transaction per clock
// while the output side is not stalled and has ten register stages. One stage
// registers the offset subtraction and clamp, six come from the three
// reciprocal-multiply dividers (/60, /60, /35064), each a multiply stage plus
// a remainder fix-up stage, and three find the year in the cycle, the day of
// year, and the month and day.
// Backpressure stalls only the stages that are full.
// Write the offset only while the pipeline is empty.
module epoch_seconds_to_calendar_core import ecal_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [16:0] i_cfg_wr_data,   // tz_offset, signed seconds
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [31:0] epoch_seconds
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [5:0] sec_field, [11:6] min_field, [16:12] hour_field,
    // [21:17] day_of_month, [25:22] month_index, [33:26] year_offset, rest zero
    output logic [39:0] o_m_axis_tdata
);

    logic [16:0] r_tz;
    logic        r_vld1;
    logic [32:0] r_time1;
    logic        w_rdy1;
    logic        w_split_rdy;
    logic        w_split_vld;
    logic        w_date_rdy;
    t_split      w_split;
    t_cal        w_res;
    logic [33:0] w_local;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tz <= '0;
        end else if (i_cfg_wr_en) begin
            r_tz <= i_cfg_wr_data;
        end
    end

    // local = epoch - offset, 34-bit signed; may exceed 2^32 for west offsets
    assign w_local = {2'b0, i_s_axis_tdata} - {{17{r_tz[16]}}, r_tz};

    assign w_rdy1          = !r_vld1 || w_split_rdy;
    assign o_s_axis_tready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else if (w_rdy1) begin
            r_vld1 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_s_axis_tvalid) begin
            r_time1 <= w_local[33] ? 33'd0 : w_local[32:0];
        end
    end

    ecal_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld1),
        .o_rdy   (w_split_rdy),
        .i_time  (r_time1),
        .o_vld   (w_split_vld),
        .i_rdy   (w_date_rdy),
        .o_data  (w_split)
    );

    ecal_date u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_split_vld),
        .o_rdy   (w_date_rdy),
        .i_data  (w_split),
        .o_vld   (o_m_axis_tvalid),
        .i_rdy   (i_m_axis_tready),
        .o_res   (w_res)
    );

    assign o_m_axis_tdata = {6'b0, w_res.year_offset, w_res.month_index,
                             w_res.day_of_month, w_res.hour_field,
                             w_res.min_field, w_res.sec_field};

endmodule
